/* src/atrts_pkg.sv */
package atrts_pkg;

  // Command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  // Result status codes carried in the output tuser
  typedef enum logic [2:0] {
    ST_COLLECTING = 3'd0,
    ST_TERMINATOR = 3'd1,
    ST_TO_PARTIAL = 3'd2,
    ST_TO_EMPTY   = 3'd3,
    ST_GARBLED    = 3'd4,
    ST_INACTIVE   = 3'd5
  } status_t;

  // Terminator words
  typedef enum logic [1:0] {
    WORD_OK      = 2'd0,
    WORD_ERROR   = 2'd1,
    WORD_CONNECT = 2'd2,
    WORD_CARRIER = 2'd3
  } word_t;

  localparam int WORD_COUNT = 4;
  localparam int WORD_MAX   = 10;

  localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{4'd2, 4'd5, 4'd7, 4'd10};

  localparam logic [7:0] WORD_TEXT [WORD_COUNT][WORD_MAX] = '{
    '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T", 8'h00, 8'h00, 8'h00},
    '{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R"}
  };

  // Match progress of each word: length of the longest prefix ending the text
  typedef struct packed {
    logic [1:0] ok;
    logic [2:0] err;
    logic [2:0] con;
    logic [3:0] car;
  } prog_t;

  typedef struct packed {
    prog_t prog;
    logic  hit;
    word_t which;
  } match_t;

  // Longest prefix of word w that ends (prefix of length p) followed by c.
  // Everything but p and c is constant, so this folds into a small mux.
  function automatic logic [3:0] advance(input int w, input logic [3:0] p,
                                         input logic [7:0] c);
    logic [3:0] pp;
    logic [3:0] res;
    logic       found;
    logic       okm;
    int         idx;
    pp    = (p >= WORD_LEN[w]) ? 4'd0 : p;
    res   = 4'd0;
    found = 1'b0;
    for (int k = WORD_MAX; k >= 1; k--) begin
      okm = 1'b1;
      for (int i = 0; i < WORD_MAX - 1; i++) begin
        idx = (i + 1 < k) ? int'(pp) + 1 - k + i : 0;
        if (i + 1 < k) begin
          if (idx < 0 || idx >= WORD_MAX) begin
            okm = 1'b0;
          end else if (WORD_TEXT[w][idx] != WORD_TEXT[w][i]) begin
            okm = 1'b0;
          end
        end
      end
      if (!found && okm && k <= int'(pp) + 1 && k <= int'(WORD_LEN[w]) &&
          WORD_TEXT[w][k-1] == c) begin
        res   = 4'(k);
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

/* src/at_response_terminator_scanner.sv */
// AT response terminator scanner.
// Input stream (s_axis): tuser carries the command (start, byte, timeout),
// tdata the received character. Every accepted item yields exactly one
// result on the output stream (m_axis): tuser is the status, tdata holds
// the matched word and the byte count of the current response.
// The cfg channel writes the capacity register; it is always ready and
// should be written only while no item is in flight.
// An item is registered in the input register at its input transfer and
// evaluated from there into the output register, which drives m_axis.
// One item per cycle is sustained while the receiver is ready: the input
// register frees itself in the same cycle that its result loads the
// output register.
// When the receiver stalls, the result holds in the output register and the
// input register keeps one more item; then s_axis_tready drops.
// Reset empties both registers, sets capacity to 256 and leaves the block
// not active with a zero count until a start command arrives.
module at_response_terminator_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // which_word[1:0], length[17:2], zero fill
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // capacity[15:0]
);
  import atrts_pkg::*;

  // Input register
  logic       in_valid;
  logic [1:0] in_cmd;
  logic [7:0] in_byte;

  // Scanner state
  logic [15:0] capacity;
  logic [15:0] byte_count, byte_count_next;
  logic        active, active_next;
  logic        zero_seen, zero_seen_next;
  prog_t       prog, prog_next;

  // Output register
  logic        out_valid;
  status_t     out_status, status_next;
  word_t       out_which, which_next;
  logic [15:0] out_length;

  logic        advance_en;
  logic [15:0] limit;
  logic [15:0] count_inc;
  match_t      match;

  assign advance_en    = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance_en;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {6'd0, out_length, out_which};

  assign limit     = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
  assign count_inc = byte_count + 16'd1;

  atrts_matcher u_matcher (
    .prog    (prog),
    .rx_byte (in_byte),
    .result  (match)
  );

  // Evaluate the registered item against the current state
  always_comb begin
    byte_count_next = byte_count;
    active_next     = active;
    zero_seen_next  = zero_seen;
    prog_next       = prog;
    status_next     = active ? ST_COLLECTING : ST_INACTIVE;
    which_next      = WORD_OK;
    case (in_cmd)
      CMD_START: begin
        byte_count_next = 16'd0;
        zero_seen_next  = 1'b0;
        prog_next       = '0;
        if (capacity < 16'd2) begin
          active_next = 1'b0;
          status_next = ST_GARBLED;
        end else begin
          active_next = 1'b1;
          status_next = ST_COLLECTING;
        end
      end
      CMD_BYTE: begin
        if (active) begin
          if (byte_count >= limit) begin
            active_next = 1'b0;
            status_next = ST_GARBLED;
          end else begin
            byte_count_next = count_inc;
            zero_seen_next  = zero_seen || (in_byte == 8'd0);
            if (!zero_seen_next) begin
              prog_next = match.prog;
            end
            if (!zero_seen_next && match.hit) begin
              active_next = 1'b0;
              status_next = ST_TERMINATOR;
              which_next  = match.which;
            end else if (count_inc >= limit) begin
              active_next = 1'b0;
              status_next = ST_GARBLED;
            end
          end
        end
      end
      CMD_TIMEOUT: begin
        if (active) begin
          active_next = 1'b0;
          status_next = (byte_count != 16'd0) ? ST_TO_PARTIAL : ST_TO_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      out_valid  <= 1'b0;
      capacity   <= 16'd256;
      byte_count <= 16'd0;
      active     <= 1'b0;
      zero_seen  <= 1'b0;
      prog       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance_en) begin
        in_valid <= 1'b0;
      end
      if (advance_en) begin
        out_valid  <= 1'b1;
        byte_count <= byte_count_next;
        active     <= active_next;
        zero_seen  <= zero_seen_next;
        prog       <= prog_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
    if (advance_en) begin
      out_status <= status_next;
      out_which  <= which_next;
      out_length <= byte_count_next;
    end
  end

endmodule

/* src/atrts_matcher.sv */
module atrts_matcher (
  input  atrts_pkg::prog_t  prog,
  input  logic [7:0]        rx_byte,
  output atrts_pkg::match_t result
);
  import atrts_pkg::*;

  logic [3:0] p_ok;
  logic [3:0] p_err;
  logic [3:0] p_con;
  logic [3:0] p_car;

  // Advance every word's progress by one byte
  assign p_ok  = advance(0, {2'b00, prog.ok}, rx_byte);
  assign p_err = advance(1, {1'b0, prog.err}, rx_byte);
  assign p_con = advance(2, {1'b0, prog.con}, rx_byte);
  assign p_car = advance(3, prog.car, rx_byte);

  // Report the first word that completed, OK first
  always_comb begin
    result.prog.ok  = p_ok[1:0];
    result.prog.err = p_err[2:0];
    result.prog.con = p_con[2:0];
    result.prog.car = p_car;
    result.hit      = 1'b1;
    if (p_ok == WORD_LEN[0]) begin
      result.which = WORD_OK;
    end else if (p_err == WORD_LEN[1]) begin
      result.which = WORD_ERROR;
    end else if (p_con == WORD_LEN[2]) begin
      result.which = WORD_CONNECT;
    end else if (p_car == WORD_LEN[3]) begin
      result.which = WORD_CARRIER;
    end else begin
      result.hit   = 1'b0;
      result.which = WORD_OK;
    end
  end

endmodule

/* src/atrts_checker.sv */
module atrts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import atrts_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A word is reported only with a terminator
  a_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_TERMINATOR |-> m_axis_tdata[1:0] == WORD_OK)
    else $error("word code without terminator");

  // A terminator needs at least two received bytes
  a_term_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_TERMINATOR |-> m_axis_tdata[17:2] >= 16'd2)
    else $error("terminator with too short a response");

  // Timeout kind agrees with the length
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_TO_EMPTY || m_axis_tuser == ST_TO_PARTIAL) |->
      ((m_axis_tuser == ST_TO_EMPTY) == (m_axis_tdata[17:2] == 16'd0)))
    else $error("timeout status disagrees with length");

  // Padding and status range
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0 && m_axis_tuser <= ST_INACTIVE)
    else $error("bad fill or status code");

endmodule

bind at_response_terminator_scanner atrts_checker u_atrts_checker (.*);
